@@ design/scl_pkg.sv @@
// package for the strided conv1d layer: constants, codes, state types
// and the register clamp helper; no dependencies
`default_nettype none
package scl_pkg;

	localparam int DEF_MAX_IN_CH  = 16;
	localparam int DEF_MAX_OUT_CH = 16;
	localparam int DEF_MAX_TAPS   = 16;
	localparam int DEF_DATA_BITS  = 16;

	localparam int OP_W    = 2;
	localparam int IDX_W   = 12;
	localparam int CFG_W   = 16;
	localparam int CFG_IW  = 3;
	localparam int RES_W   = 32;
	localparam int RCH_W   = 4;
	localparam int POS_W   = 16;
	localparam int CNT_W   = 7;
	localparam int PHASE_W = 4;
	localparam int MAX_STRIDE = 16;

	typedef enum logic [OP_W-1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_IN_CH  = 3'd0,
		REG_OUT_CH = 3'd1,
		REG_TAPS   = 3'd2,
		REG_STRIDE = 3'd3,
		REG_FRAME  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic init;
		logic mul_v;
	} mac_ctl_t;

	function automatic logic [CNT_W-1:0] clamp_cnt(input logic [4:0] v, input int maxv);
		logic [CNT_W-1:0] r;
		if (v == 5'd0)
			r = CNT_W'(1);
		else if (int'(v) > maxv)
			r = CNT_W'(maxv);
		else
			r = CNT_W'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/scl_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module scl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ design/scl_tap_cell.sv @@
// one tap cell of the sample window: holds one sample per input channel
// and hands its old sample to the next cell on a push; uses scl_pkg
`default_nettype none
module scl_tap_cell #(
	parameter int MAX_IN_CH = scl_pkg::DEF_MAX_IN_CH,
	parameter int DATA_BITS = scl_pkg::DEF_DATA_BITS,
	parameter int IXW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 shift_en,
	input  wire logic [IXW-1:0]       shift_ch,
	input  wire logic [DATA_BITS-1:0] shift_in,
	output logic      [DATA_BITS-1:0] shift_out,
	input  wire logic [IXW-1:0]       rd_ch,
	output logic      [DATA_BITS-1:0] rd_data
);
	logic [DATA_BITS-1:0] smp_q [MAX_IN_CH];

	assign shift_out = smp_q[shift_ch];
	assign rd_data   = smp_q[rd_ch];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_IN_CH; c++)
				smp_q[c] <= '0;
		end else if (shift_en) begin
			smp_q[shift_ch] <= shift_in;
		end
	end
endmodule
`default_nettype wire

@@ design/scl_mac.sv @@
// multiply accumulate unit with round half up and 32 bit saturation
// uses scl_pkg
`default_nettype none
module scl_mac #(
	parameter int DATA_BITS = scl_pkg::DEF_DATA_BITS,
	parameter int ACC_W = 2 * DATA_BITS + 14
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire scl_pkg::mac_ctl_t           ctl,
	input  wire logic signed [DATA_BITS-1:0] bias,
	input  wire logic signed [DATA_BITS-1:0] weight,
	input  wire logic signed [DATA_BITS-1:0] sample,
	output logic                             busy,
	output logic signed [scl_pkg::RES_W-1:0] result
);
	import scl_pkg::*;

	localparam int F = DATA_BITS - 1;
	localparam int CMP_W = (ACC_W > 33) ? ACC_W : 33;
	localparam logic signed [CMP_W-1:0] SMAX = CMP_W'(64'sd2147483647);
	localparam logic signed [CMP_W-1:0] SMIN = -CMP_W'(64'sd2147483648);

	logic signed [2*DATA_BITS-1:0] prod_s2;
	logic                          v_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       rnd;
	logic signed [CMP_W-1:0]       q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= ctl.mul_v;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= weight * sample;
		if (ctl.init)
			acc_q <= ACC_W'(bias) <<< F;
		else if (v_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
	end

	always_comb begin
		rnd = acc_q + (ACC_W'(1) <<< (F - 1));
		q = CMP_W'(rnd >>> F);
		if (q > SMAX)
			result = RES_W'(SMAX);
		else if (q < SMIN)
			result = RES_W'(SMIN);
		else
			result = RES_W'(q);
	end

	assign busy = v_s2;
endmodule
`default_nettype wire

@@ design/strided_conv1d_layer.sv @@
// strided conv1d layer top: window cell chain, weight/bias rams, mac
// sequencer; uses scl_pkg, scl_ram, scl_tap_cell, scl_mac
// a weight, bias or non-emitting sample beat is taken while idle and leaves the layer idle
// an emitting sample starts out_channels runs of in_channels*kernel_taps macs each,
// one mac per cycle through the single weight ram read port; beats wait meanwhile
// results leave through an output register, one per run
// arst_n clears counters, the sample window and all valids; rams start undefined
`default_nettype none
module strided_conv1d_layer #(
	parameter int MAX_IN_CH  = scl_pkg::DEF_MAX_IN_CH,
	parameter int MAX_OUT_CH = scl_pkg::DEF_MAX_OUT_CH,
	parameter int MAX_TAPS   = scl_pkg::DEF_MAX_TAPS,
	parameter int DATA_BITS  = scl_pkg::DEF_DATA_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [scl_pkg::CFG_IW-1:0]    cfg_index,
	input  wire logic [scl_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [scl_pkg::OP_W-1:0]      operation,
	input  wire logic [scl_pkg::IDX_W-1:0]     entry_index,
	input  wire logic signed [DATA_BITS-1:0]   data_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [scl_pkg::RES_W-1:0]   result_value,
	output logic [scl_pkg::RCH_W-1:0]          result_channel,
	output logic [scl_pkg::POS_W-1:0]          result_position,
	output logic                               last_of_run
);
	import scl_pkg::*;

	localparam int IXW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
	localparam int OXW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
	localparam int TXW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int WD  = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
	localparam int ACC_W = 2 * DATA_BITS + $clog2(MAX_IN_CH * MAX_TAPS + 1) + 2;

	logic [4:0]  in_ch_q, out_ch_q, taps_q, stride_q;
	logic [15:0] frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= 5'd1;
			out_ch_q <= 5'd1;
			taps_q   <= 5'd1;
			stride_q <= 5'd1;
			frame_q  <= 16'd1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_IN_CH:  in_ch_q  <= cfg_data[4:0];
				REG_OUT_CH: out_ch_q <= cfg_data[4:0];
				REG_TAPS:   taps_q   <= cfg_data[4:0];
				REG_STRIDE: stride_q <= cfg_data[4:0];
				REG_FRAME:  frame_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CNT_W-1:0] nin, nout, ktaps, stride;
	assign nin    = clamp_cnt(in_ch_q, MAX_IN_CH);
	assign nout   = clamp_cnt(out_ch_q, MAX_OUT_CH);
	assign ktaps  = clamp_cnt(taps_q, MAX_TAPS);
	assign stride = clamp_cnt(stride_q, MAX_STRIDE);

	state_t state_q, state_d;
	logic   in_beat, push, wr_w, wr_b;

	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign push     = in_beat && (op_t'(operation) == OP_SAMPLE);
	assign wr_w     = in_beat && (op_t'(operation) == OP_WEIGHT) && (32'(entry_index) < WD);
	assign wr_b     = in_beat && (op_t'(operation) == OP_BIAS) && (32'(entry_index) < MAX_OUT_CH);

	// frame counters
	logic [IXW-1:0]     ch_q, ch_sel;
	logic [15:0]        time_q, pos_q, pos_emit_q;
	logic [PHASE_W-1:0] phase_q;
	logic               last_ch, kt_ok, emit, frame_end;
	logic [16:0]        time_nx, flen;

	always_comb begin
		if (CNT_W'(ch_q) >= nin - CNT_W'(1))
			ch_sel = IXW'(nin - CNT_W'(1));
		else
			ch_sel = ch_q;
		last_ch   = (CNT_W'(ch_sel) + CNT_W'(1) >= nin);
		time_nx   = {1'b0, time_q} + 17'd1;
		flen      = (frame_q == 16'd0) ? 17'h10000 : {1'b0, frame_q};
		kt_ok     = (time_nx >= 17'(ktaps));
		emit      = kt_ok && (phase_q == '0);
		frame_end = (time_nx >= flen);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q       <= '0;
			time_q     <= '0;
			phase_q    <= '0;
			pos_q      <= '0;
			pos_emit_q <= '0;
		end else if (push) begin
			if (!last_ch) begin
				ch_q <= ch_sel + IXW'(1);
			end else begin
				ch_q       <= '0;
				pos_emit_q <= pos_q;
				if (frame_end) begin
					time_q  <= '0;
					phase_q <= '0;
					pos_q   <= '0;
				end else begin
					time_q <= time_nx[15:0];
					if (kt_ok)
						phase_q <= ({1'b0, phase_q} + 5'd1 >= 5'(stride)) ? '0
							: phase_q + PHASE_W'(1);
					if (emit)
						pos_q <= pos_q + 16'd1;
				end
			end
		end
	end

	// sample window: chain of tap cells
	logic [DATA_BITS-1:0] cell_sh [MAX_TAPS];
	logic [DATA_BITS-1:0] cell_rd [MAX_TAPS];
	logic [IXW-1:0]       i_q;
	logic [OXW-1:0]       o_q;
	logic [TXW-1:0]       j_q, tap_sel;
	logic [WAW-1:0]       waddr_q;

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		logic [DATA_BITS-1:0] sin;
		if (k == 0) begin : g_head
			assign sin = data_value;
		end else begin : g_link
			assign sin = cell_sh[k-1];
		end
		scl_tap_cell #(
			.MAX_IN_CH (MAX_IN_CH),
			.DATA_BITS (DATA_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (push),
			.shift_ch  (ch_sel),
			.shift_in  (sin),
			.shift_out (cell_sh[k]),
			.rd_ch     (i_q),
			.rd_data   (cell_rd[k])
		);
	end

	// weight and bias stores
	logic [DATA_BITS-1:0] w_rd, b_rd;

	scl_ram #(.WIDTH(DATA_BITS), .DEPTH(WD)) u_wram (
		.clk   (clk),
		.we    (wr_w),
		.waddr (WAW'(entry_index)),
		.wdata (data_value),
		.raddr (waddr_q),
		.rdata (w_rd)
	);

	scl_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_OUT_CH)) u_bram (
		.clk   (clk),
		.we    (wr_b),
		.waddr (OXW'(entry_index)),
		.wdata (data_value),
		.raddr (o_q),
		.rdata (b_rd)
	);

	// sequencer
	logic                 last_j, last_i, last_o, v_s1, mac_busy, drain_ok;
	logic [DATA_BITS-1:0] samp_s1;
	mac_ctl_t             mctl;
	logic signed [RES_W-1:0] mac_res;

	assign tap_sel  = TXW'(ktaps - CNT_W'(1) - CNT_W'(j_q));
	assign last_j   = (CNT_W'(j_q) == ktaps - CNT_W'(1));
	assign last_i   = (CNT_W'(i_q) == nin - CNT_W'(1));
	assign last_o   = (CNT_W'(o_q) == nout - CNT_W'(1));
	assign drain_ok = !v_s1 && !mac_busy && (!out_valid || !out_stall);
	assign mctl.init  = (state_q == ST_MAC) && (i_q == '0) && (j_q == '0);
	assign mctl.mul_v = v_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (push && last_ch && emit) state_d = ST_BIAS;
			ST_BIAS:  state_d = ST_MAC;
			ST_MAC:   if (last_j && last_i) state_d = ST_DRAIN;
			ST_DRAIN: if (drain_ok) state_d = last_o ? ST_IDLE : ST_BIAS;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			waddr_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_MAC);
			case (state_q)
				ST_IDLE: begin
					o_q     <= '0;
					i_q     <= '0;
					j_q     <= '0;
					waddr_q <= '0;
				end
				ST_MAC: begin
					waddr_q <= waddr_q + WAW'(1);
					if (last_j) begin
						j_q <= '0;
						i_q <= last_i ? '0 : i_q + IXW'(1);
					end else begin
						j_q <= j_q + TXW'(1);
					end
				end
				ST_DRAIN: if (drain_ok && !last_o) o_q <= o_q + OXW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		samp_s1 <= cell_rd[tap_sel];
	end

	scl_mac #(.DATA_BITS(DATA_BITS), .ACC_W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.bias   (b_rd),
		.weight (w_rd),
		.sample (samp_s1),
		.busy   (mac_busy),
		.result (mac_res)
	);

	// output register
	logic load;
	assign load = (state_q == ST_DRAIN) && drain_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (load)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_value    <= mac_res;
			result_channel  <= RCH_W'(o_q);
			result_position <= pos_emit_q;
			last_of_run     <= last_o;
		end
	end
endmodule
`default_nettype wire

@@ design/scl_checker.sv @@
// port level checks for the strided conv1d layer, bound to the top level
// uses scl_pkg
`default_nettype none
module scl_checker #(
	parameter int DATA_BITS = scl_pkg::DEF_DATA_BITS
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic [scl_pkg::OP_W-1:0]    operation,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [scl_pkg::RES_W-1:0]   result_value,
	input wire logic                        last_of_run
);
	import scl_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_value))
		else $error("stalled result changed");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |-> in_stall)
		else $error("input taken in the middle of a run");

	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == OP_WEIGHT || operation == OP_BIAS)
		|=> !in_stall)
		else $error("store write started a run");
endmodule

bind strided_conv1d_layer scl_checker #(.DATA_BITS(DATA_BITS)) u_scl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.operation    (operation),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value),
	.last_of_run  (last_of_run)
);
`default_nettype wire

@@ tb/scl_result_checker.sv @@
`timescale 1ns / 1ps
// result checker for the strided conv1d layer: watches the register port and
// both beat channels, predicts every result and compares it; uses scl_pkg
module scl_result_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [scl_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [scl_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic [scl_pkg::OP_W-1:0]    operation,
	input  wire logic [scl_pkg::IDX_W-1:0]   entry_index,
	input  wire logic signed [15:0]          data_value,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic signed [31:0]          result_value,
	input  wire logic [3:0]                  result_channel,
	input  wire logic [15:0]                 result_position,
	input  wire logic                        last_of_run,
	output int                               errors,
	output int                               pending
);
	import scl_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		logic [3:0]         chan;
		logic [15:0]        pos;
		logic               last;
	} conv_result_t;

	conv_result_t conv_q[$];
	logic signed [15:0] weight_mem [4096];
	logic signed [15:0] bias_mem [16];
	logic signed [15:0] taps_win [16][16];
	logic [4:0] r_in, r_out, r_taps, r_stride;
	logic [15:0] r_frame;
	int chan_cnt, time_cnt, phase_cnt;
	logic [15:0] pos_cnt;

	function automatic int eff(input logic [4:0] v);
		int r;
		r = (v == 0) ? 1 : ((v > 16) ? 16 : int'(v));
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic push_sample(input logic signed [15:0] val);
		int nin, nout, kt, st, flen, ch;
		longint acc, q;
		bit emit;
		conv_result_t r;
		nin = eff(r_in);
		nout = eff(r_out);
		kt = eff(r_taps);
		st = eff(r_stride);
		flen = (r_frame == 0) ? 65536 : int'(r_frame);
		emit = 0;
		ch = (chan_cnt >= nin) ? nin - 1 : chan_cnt;
		for (int k = 15; k > 0; k--)
			taps_win[ch][k] = taps_win[ch][k-1];
		taps_win[ch][0] = val;
		if (ch + 1 < nin) begin
			chan_cnt = ch + 1;
			return;
		end
		chan_cnt = 0;
		if (time_cnt + 1 >= kt) begin
			emit = (phase_cnt == 0);
			phase_cnt = (phase_cnt + 1 >= st) ? 0 : phase_cnt + 1;
		end
		if (emit) begin
			for (int o = 0; o < nout; o++) begin
				acc = longint'(bias_mem[o]) <<< 15;
				for (int i = 0; i < nin; i++)
					for (int j = 0; j < kt; j++)
						acc += longint'(weight_mem[o*nin*kt + i*kt + j]) *
							longint'(taps_win[i][kt-1-j]);
				q = (acc + 64'sd16384) >>> 15;
				if (q > 64'sd2147483647) q = 64'sd2147483647;
				if (q < -64'sd2147483648) q = -64'sd2147483648;
				r.value = q[31:0];
				r.chan = o[3:0];
				r.pos = pos_cnt;
				r.last = (o + 1 == nout);
				conv_q.push_back(r);
			end
			pos_cnt++;
		end
		if (time_cnt + 1 >= flen) begin
			time_cnt = 0;
			phase_cnt = 0;
			pos_cnt = 0;
		end else
			time_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		conv_result_t w;
		if (!arst_n) begin
			r_in = 1; r_out = 1; r_taps = 1; r_stride = 1; r_frame = 1;
			chan_cnt = 0; time_cnt = 0; phase_cnt = 0; pos_cnt = 0;
			foreach (taps_win[i, j]) taps_win[i][j] = 0;
			conv_q.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_IN_CH:  r_in = cfg_data[4:0];
					REG_OUT_CH: r_out = cfg_data[4:0];
					REG_TAPS:   r_taps = cfg_data[4:0];
					REG_STRIDE: r_stride = cfg_data[4:0];
					REG_FRAME:  r_frame = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (op_t'(operation))
					OP_WEIGHT: weight_mem[entry_index] = data_value;
					OP_BIAS:   if (entry_index < 16) bias_mem[entry_index] = data_value;
					OP_SAMPLE: push_sample(data_value);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (conv_q.size() == 0)
					report("unexpected beat, value", result_value, 0);
				else begin
					w = conv_q.pop_front();
					if (result_value !== w.value) report("value", result_value, w.value);
					if (result_channel !== w.chan) report("channel", result_channel, w.chan);
					if (result_position !== w.pos) report("position", result_position, w.pos);
					if (last_of_run !== w.last) report("last", last_of_run, w.last);
				end
			end
		end
		pending = conv_q.size();
	end

	initial errors = 0;
endmodule

@@ tb/tb_strided_conv1d_layer.sv @@
`timescale 1ns / 1ps
// testbench top for strided_conv1d_layer: drives registers, weight, bias
// and sample beats with random idling; scl_result_checker does the checking
module tb_strided_conv1d_layer;
	import scl_pkg::*;

	localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd5;

	logic clk, arst_n, cfg_we, in_valid, out_stall;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic [OP_W-1:0] operation;
	logic [IDX_W-1:0] entry_index;
	logic signed [15:0] data_value;
	wire logic in_stall, out_valid, last_of_run;
	wire logic signed [31:0] result_value;
	wire logic [3:0] result_channel;
	wire logic [15:0] result_position;
	int errors, pending, rand_items;
	bit quiet;
	bit weight_done [4096];
	bit bias_done [16];

	strided_conv1d_layer u_dut (.*);
	scl_result_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk or negedge arst_n)
		if (!arst_n) out_stall <= 0;
		else out_stall <= !quiet && ($urandom_range(99) < 13);

	task automatic send(input op_t op, input int idx, input int val);
		if (!quiet && $urandom_range(99) < 13) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		operation <= op;
		entry_index <= idx[11:0];
		data_value <= val[15:0];
		if (op == OP_WEIGHT) weight_done[idx[11:0]] = 1;
		if (op == OP_BIAS && idx < 16) bias_done[idx] = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(negedge clk);
		@(posedge clk);
	endtask

	// write enable stays high across back to back writes; caller drops it
	task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		@(posedge clk);
	endtask

	function automatic int eff(input int v);
		int r;
		r = v & 31;
		r = (r == 0) ? 1 : ((r > 16) ? 16 : r);
		return r;
	endfunction

	task automatic run_phase(input int nin, nout, kt, st, flen, nbeats);
		int n, r;
		drain();
		cfg_write(REG_IN_CH, nin);
		cfg_write(REG_OUT_CH, nout);
		cfg_write(REG_TAPS, kt);
		cfg_write(REG_STRIDE, st);
		cfg_write(REG_FRAME, flen);
		cfg_we <= 0;
		n = eff(nout) * eff(nin) * eff(kt);
		for (int a = 0; a < n; a++)
			if (!weight_done[a]) send(OP_WEIGHT, a, $urandom);
		for (int o = 0; o < eff(nout); o++)
			if (!bias_done[o]) send(OP_BIAS, o, $urandom);
		for (int b = 0; b < nbeats; b++) begin
			r = $urandom_range(99);
			if (r < 5) send(OP_NONE, $urandom, $urandom);
			else if (r < 11) send(OP_WEIGHT, $urandom_range(4095), $urandom);
			else if (r < 15) send(OP_BIAS, $urandom_range(31), $urandom);
			else send(OP_SAMPLE, $urandom, $urandom);
			rand_items++;
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; operation = OP_NONE; entry_index = 0; data_value = 0;
		quiet = 0;
		rand_items = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: one channel, one tap, frame of one step
		send(OP_WEIGHT, 0, 32767);
		send(OP_BIAS, 0, -32768);
		send(OP_BIAS, 16, 5);
		send(OP_BIAS, 4095, 7);
		send(OP_WEIGHT, 4095, -1);
		send(OP_NONE, 4095, -1);
		send(OP_SAMPLE, 0, 32767);
		send(OP_SAMPLE, 4095, -32768);
		send(OP_SAMPLE, 0, 0);
		send(OP_SAMPLE, 0, -1);
		send(OP_WEIGHT, 0, -32768);
		send(OP_BIAS, 0, 32767);
		send(OP_SAMPLE, 0, -32768);
		send(OP_SAMPLE, 0, 32767);
		drain();
		cfg_write(REG_UNUSED, 3);
		cfg_we <= 0;

		// extremes, out of range values, short frame
		run_phase(0, 16, 1, 1, 5, 12);
		run_phase(16, 2, 2, 31, 0, 70);
		run_phase(1, 3, 31, 3, 40, 45);
		run_phase(3, 2, 3, 16, 7, 25);
		run_phase(2, 1, 5, 1, 3, 12);
		run_phase(32, 1, 1, 0, 65535, 20);
		run_phase(1, 16, 16, 1, 30, 20);

		rand_items = 0;
		while (rand_items < 270) begin
			quiet = (rand_items > 100 && rand_items < 160);
			if ($urandom_range(9) == 0)
				run_phase($urandom_range(31), $urandom_range(31), $urandom_range(5),
					$urandom_range(31), $urandom, $urandom_range(20, 40));
			else
				run_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
					$urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(20, 40));
		end
		quiet = 0;
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
